[design/box_downsample_rgba16_macros.svh]
// ----------------------------------------------------------------------------
// box_downsample_rgba16 assertion macros
// shared concurrent assertion forms for the downsampler rtl
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_RGBA16_MACROS_SVH
`define BOX_DOWNSAMPLE_RGBA16_MACROS_SVH

// property must hold at every clock edge outside reset
`define BDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true at a clock edge outside reset
`define BDS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[design/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg
// types, constants and helpers for the rgba16 box downsampler
// ----------------------------------------------------------------------------
package bds_pkg;

   localparam int CHAN_W      = 16;
   localparam int CHANNELS    = 4;
   localparam int SUM_W       = 40;
   localparam int PIX_W       = CHAN_W * CHANNELS;
   localparam int COORD_W     = 12;
   localparam int RSP_W       = PIX_W + 2 * COORD_W;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;
   localparam int SHIFT_W     = 5;
   localparam int OFIFO_DEPTH = 4;
   localparam int OFIFO_AW    = 2;
   localparam int OFIFO_CW    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH_LOG2    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT_LOG2   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_RATIO_LOG2  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_RATIO_LOG2 = 4'd3;

   typedef logic [CSR_DATA_W-1:0] log2_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef sum_type [CHANNELS-1:0] sums_type;
   typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_type;

   typedef struct packed {
      logic               frame_end;
      logic [COORD_W-1:0] dest_y;
      logic [COORD_W-1:0] dest_x;
      pix_type            avg;
   } rsp_word_type;

   function automatic logic [CHAN_W-1:0] block_avg(input sum_type s,
                                                   input logic [SHIFT_W-1:0] sh);
      sum_type t;
      t = s >> sh;
      return t[CHAN_W-1:0];
   endfunction

endpackage

[design/box_downsample_rgba16.sv]
// ----------------------------------------------------------------------------
// box_downsample_rgba16
// box-filter downsampler for 16-bit rgba pixels in raster order, with
// per-column block sums held in a synchronous memory
// ----------------------------------------------------------------------------
//  channel   dir  ports                                 word
//  req       in   req_tvalid/req_tready/req_tdata       one source pixel
//  rsp       out  rsp_tvalid/rsp_tready/rsp_tdata/tlast one block average
//  csr       in   csr_we/csr_index/csr_wdata            register write
//
//  one pixel accepted per cycle while req_tready is high; a block result
//  passes the add stage, the shift stage and the result queue before it is
//  visible on rsp; the sum memory read-modify-write loop (read, add, write
//  back with a one-word forwarding register) sets the rate of one word per cycle
//  reset is synchronous and needs no clearing pass: each block's first pixel
//  loads its sum rather than adding to it
//  a 4-word result queue is filled on credit, so req_tready drops only when
//  rsp stalls long enough to use the credits up
// ----------------------------------------------------------------------------
`include "box_downsample_rgba16_macros.svh"

module box_downsample_rgba16 #(
   parameter int MAX_WIDTH_LOG2  = 12,
   parameter int MAX_HEIGHT_LOG2 = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // red_in, green_in, blue_in, alpha_in
   input  logic [bds_pkg::PIX_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // red_out, green_out, blue_out, alpha_out, dest_x, dest_y
   output logic [bds_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [bds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bds_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bds_pkg::*;

   localparam int MW    = MAX_WIDTH_LOG2;
   localparam int MH    = MAX_HEIGHT_LOG2;
   localparam int DEPTH = 1 << MW;
   localparam int XW    = (MW > COORD_W) ? MW : COORD_W;
   localparam int YW    = (MH > COORD_W) ? MH : COORD_W;
   localparam log2_type MW_LIM = CSR_DATA_W'(MAX_WIDTH_LOG2);
   localparam log2_type MH_LIM = CSR_DATA_W'(MAX_HEIGHT_LOG2);

   // configuration
   log2_type cfg_sw_ff, cfg_sw_in;
   log2_type cfg_sh_ff, cfg_sh_in;
   log2_type cfg_wr_ff, cfg_wr_in;
   log2_type cfg_hr_ff, cfg_hr_in;

   // position counters
   logic [MW-1:0] col_ff, col_in;
   logic [MH-1:0] row_ff, row_in;

   // front-end decode
   log2_type sw, sh, wr, hr;
   logic [MW-1:0] wlast, wmask, col, dx, lx;
   logic [MH-1:0] hlast, hmask, row, dy, ly;
   logic [XW-1:0] dx_wide;
   logic [YW-1:0] dy_wide;
   logic [SHIFT_W-1:0] shift;
   logic first, last, fend, accept;

   // sum memory and read port
   sums_type sum_mem [DEPTH];
   sums_type rd_sums_ff;
   sums_type fwd_sums_ff;

   // add stage
   logic               s1_valid_ff;
   logic [MW-1:0]      s1_idx_ff;
   pix_type            s1_pix_ff;
   logic               s1_first_ff, s1_last_ff, s1_fwd_ff, s1_fend_ff;
   logic [SHIFT_W-1:0] s1_shift_ff;
   logic [COORD_W-1:0] s1_dx_ff, s1_dy_ff;
   logic               s1_emit, fwd_in;
   sums_type           s2_sum_in;

   // shift stage
   logic               s2_valid_ff;
   sums_type           s2_sum_ff;
   logic [SHIFT_W-1:0] s2_shift_ff;
   logic [COORD_W-1:0] s2_dx_ff, s2_dy_ff;
   logic               s2_fend_ff;
   rsp_word_type       push_word;

   // result queue
   rsp_word_type          ofifo_mem [OFIFO_DEPTH];
   logic [OFIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OFIFO_CW-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic [OFIFO_CW:0]     credit;
   logic                  pop;
   rsp_word_type          head;

   always_comb begin
      cfg_sw_in = cfg_sw_ff;
      cfg_sh_in = cfg_sh_ff;
      cfg_wr_in = cfg_wr_ff;
      cfg_hr_in = cfg_hr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH_LOG2:    cfg_sw_in = csr_wdata;
            CSR_SRC_HEIGHT_LOG2:   cfg_sh_in = csr_wdata;
            CSR_WIDTH_RATIO_LOG2:  cfg_wr_in = csr_wdata;
            CSR_HEIGHT_RATIO_LOG2: cfg_hr_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sw = (cfg_sw_ff > MW_LIM) ? MW_LIM : cfg_sw_ff;
      sh = (cfg_sh_ff > MH_LIM) ? MH_LIM : cfg_sh_ff;
      wr = (cfg_wr_ff > sw) ? sw : cfg_wr_ff;
      hr = (cfg_hr_ff > sh) ? sh : cfg_hr_ff;
      wlast = ~({MW{1'b1}} << sw);
      hlast = ~({MH{1'b1}} << sh);
      wmask = ~({MW{1'b1}} << wr);
      hmask = ~({MH{1'b1}} << hr);
      col = col_ff & wlast;
      row = row_ff & hlast;
      dx = col >> wr;
      dy = row >> hr;
      lx = col & wmask;
      ly = row & hmask;
      dx_wide = XW'(dx);
      dy_wide = YW'(dy);
      first = (lx == '0) && (ly == '0);
      last  = (lx == wmask) && (ly == hmask);
      fend  = (col == wlast) && (row == hlast);
      shift = SHIFT_W'(wr) + SHIFT_W'(hr);
   end

   assign s1_emit = s1_valid_ff && s1_last_ff;
   assign credit = (OFIFO_CW+1)'(fifo_cnt_ff) + (OFIFO_CW+1)'(s1_emit)
                 + (OFIFO_CW+1)'(s2_valid_ff);
   assign req_tready = credit < (OFIFO_CW+1)'(OFIFO_DEPTH);
   assign accept = req_tvalid && req_tready;
   assign fwd_in = s1_valid_ff && (s1_idx_ff == dx);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col == wlast) begin
            col_in = '0;
            row_in = (row == hlast) ? '0 : row + 1'b1;
         end else begin
            col_in = col + 1'b1;
         end
      end
   end

   // block sum: a block's first pixel loads, the rest accumulate
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s2_sum_in[ch] = (s1_first_ff ? '0 : (s1_fwd_ff ? fwd_sums_ff[ch] : rd_sums_ff[ch]))
                       + SUM_W'(s1_pix_ff[ch]);
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         push_word.avg[ch] = block_avg(s2_sum_ff[ch], s2_shift_ff);
      end
      push_word.dest_x    = s2_dx_ff;
      push_word.dest_y    = s2_dy_ff;
      push_word.frame_end = s2_fend_ff;
   end

   assign head        = ofifo_mem[rd_ptr_ff];
   assign rsp_tvalid  = fifo_cnt_ff != '0;
   assign rsp_tdata   = {head.dest_y, head.dest_x, head.avg};
   assign rsp_tlast   = head.frame_end;
   assign pop         = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + OFIFO_CW'(s2_valid_ff) - OFIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         sum_mem[s1_idx_ff] <= s2_sum_in;
      end
      if (accept) begin
         rd_sums_ff <= sum_mem[dx];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         ofifo_mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= dx;
         s1_pix_ff   <= req_tdata;
         s1_first_ff <= first;
         s1_last_ff  <= last;
         s1_fwd_ff   <= fwd_in;
         s1_fend_ff  <= fend;
         s1_shift_ff <= shift;
         s1_dx_ff    <= dx_wide[COORD_W-1:0];
         s1_dy_ff    <= dy_wide[COORD_W-1:0];
         fwd_sums_ff <= s2_sum_in;
      end
      if (s1_emit) begin
         s2_sum_ff   <= s2_sum_in;
         s2_shift_ff <= s1_shift_ff;
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_fend_ff  <= s1_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff   <= '0;
         cfg_sh_ff   <= '0;
         cfg_wr_ff   <= '0;
         cfg_hr_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         cfg_sw_ff   <= cfg_sw_in;
         cfg_sh_ff   <= cfg_sh_in;
         cfg_wr_ff   <= cfg_wr_in;
         cfg_hr_ff   <= cfg_hr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_emit;
         wr_ptr_ff   <= wr_ptr_ff + OFIFO_AW'(s2_valid_ff);
         rd_ptr_ff   <= rd_ptr_ff + OFIFO_AW'(pop);
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   `BDS_ASSERT(a_ofifo_bound, clock, reset, fifo_cnt_ff <= OFIFO_CW'(OFIFO_DEPTH), "result queue count beyond depth")
   `BDS_ASSERT_NEVER(a_ofifo_overflow, clock, reset, s2_valid_ff && !pop && fifo_cnt_ff == OFIFO_CW'(OFIFO_DEPTH), "result pushed into full queue")
   `BDS_ASSERT(a_fwd_source, clock, reset, s1_valid_ff && s1_fwd_ff |-> $past(s1_valid_ff) && ($past(s1_idx_ff) == s1_idx_ff), "forwarded sum not from the previous write")
   `BDS_ASSERT(a_col_wrap, clock, reset, accept && !csr_we && col == wlast |=> col_ff == '0, "column counter failed to wrap at line end")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for box_downsample_rgba16: pixels are streamed in
// raster order under several image and block sizes, every block average is
// predicted locally and compared field by field as it leaves the rsp channel
// ----------------------------------------------------------------------------
module tb;
   import bds_pkg::*;

   localparam int MAX_W_LOG2    = 12;
   localparam int MAX_H_LOG2    = 12;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PIXELS = 520;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // red_in, green_in, blue_in, alpha_in
   logic [PIX_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // red_out, green_out, blue_out, alpha_out, dest_x, dest_y
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   box_downsample_rgba16 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // local copy of the block state
   sum_type     col_sums [4096][CHANNELS];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   log2_type    src_w_log2 = '0;
   log2_type    src_h_log2 = '0;
   log2_type    ratio_w_log2 = '0;
   log2_type    ratio_h_log2 = '0;

   rsp_word_type expected_blocks [$];

   int  errors = 0;
   int  pixels_sent = 0;
   int  blocks_checked = 0;
   int  frames_seen = 0;
   int  settings_used = 0;
   int  random_pixels = 0;
   int  stall_left = 0;
   bit  no_idle = 1'b0;
   string chan_name [CHANNELS] = '{"red", "green", "blue", "alpha"};

   function automatic int unsigned clamp_log2(input int unsigned v, input int unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] index,
                                           input log2_type value);
      case (index)
         CSR_SRC_WIDTH_LOG2:    src_w_log2 = value;
         CSR_SRC_HEIGHT_LOG2:   src_h_log2 = value;
         CSR_WIDTH_RATIO_LOG2:  ratio_w_log2 = value;
         CSR_HEIGHT_RATIO_LOG2: ratio_h_log2 = value;
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   // accumulate one pixel, return 1 with the block average when it closes a block
   function automatic bit predict_block(input pix_type pix, output rsp_word_type res);
      int unsigned sw, sh, wr, hr, wlast, hlast, wmask, hmask;
      int unsigned col, row, dx, dy, lx, ly;
      bit          hit;
      sw    = clamp_log2(src_w_log2, MAX_W_LOG2);
      sh    = clamp_log2(src_h_log2, MAX_H_LOG2);
      wr    = clamp_log2(ratio_w_log2, sw);
      hr    = clamp_log2(ratio_h_log2, sh);
      wlast = (1 << sw) - 1;
      hlast = (1 << sh) - 1;
      wmask = (1 << wr) - 1;
      hmask = (1 << hr) - 1;
      col   = col_pos & wlast;
      row   = row_pos & hlast;
      dx    = col >> wr;
      dy    = row >> hr;
      lx    = col & wmask;
      ly    = row & hmask;
      res   = '0;
      hit   = 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (lx == 0 && ly == 0) begin
            col_sums[dx][ch] = sum_type'(pix[ch]);
         end else begin
            col_sums[dx][ch] = col_sums[dx][ch] + sum_type'(pix[ch]);
         end
      end
      if (lx == wmask && ly == hmask) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            res.avg[ch] = CHAN_W'(col_sums[dx][ch] >> (wr + hr));
         end
         res.dest_x    = COORD_W'(dx);
         res.dest_y    = COORD_W'(dy);
         res.frame_end = (col == wlast && row == hlast);
         hit = 1'b1;
      end
      if (col == wlast) begin
         col_pos = 0;
         row_pos = (row == hlast) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
      return hit;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic pix_type make_pixel(input int pattern);
      pix_type pix;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         case (pattern)
            0:       pix[ch] = '1;
            1:       pix[ch] = '0;
            2:       pix[ch] = $urandom_range(0, 1) ? '1 : '0;
            default: pix[ch] = CHAN_W'($urandom);
         endcase
      end
      return pix;
   endfunction

   task automatic check_block_average();
      rsp_word_type got, want;
      got = {rsp_tlast, rsp_tdata};
      if (expected_blocks.size() == 0) begin
         $display("%0t: unexpected block word, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = expected_blocks.pop_front();
      blocks_checked++;
      if (want.frame_end) frames_seen++;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (got.avg[ch] !== want.avg[ch]) begin
            $display("%0t: %s average expected %h actual %h", $time, chan_name[ch],
                     want.avg[ch], got.avg[ch]);
            errors++;
         end
      end
      if (got.dest_x !== want.dest_x) begin
         $display("%0t: dest_x expected %0d actual %0d", $time, want.dest_x, got.dest_x);
         errors++;
      end
      if (got.dest_y !== want.dest_y) begin
         $display("%0t: dest_y expected %0d actual %0d", $time, want.dest_y, got.dest_y);
         errors++;
      end
      if (got.frame_end !== want.frame_end) begin
         $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                  got.frame_end);
         errors++;
      end
   endtask

   // result side: random stalls, check every accepted word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_block_average();
      if (stall_left == 0 && !no_idle && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_pixel(input pix_type pix);
      rsp_word_type res;
      int           gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (predict_block(pix, res)) expected_blocks.push_back(res);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input log2_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg_write(index, value);
   endtask

   task automatic configure(input log2_type sw, input log2_type sh, input log2_type wr,
                            input log2_type hr, input bit stray);
      wait_drained();
      write_reg(CSR_SRC_WIDTH_LOG2, sw);
      write_reg(CSR_SRC_HEIGHT_LOG2, sh);
      write_reg(CSR_WIDTH_RATIO_LOG2, wr);
      write_reg(CSR_HEIGHT_RATIO_LOG2, hr);
      // unmapped index only restarts the frame
      if (stray) write_reg(CSR_INDEX_W'($urandom_range(CSR_HEIGHT_RATIO_LOG2 + 1, 15)),
                           log2_type'($urandom_range(0, 15)));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_unit_image();
      // reset sizes: every pixel is a whole frame
      no_idle = 1'b1;
      send_pixel('0);
      send_pixel('1);
      send_pixel({CHANNELS{16'hAAAA}});
      send_pixel({CHANNELS{16'h5555}});
      no_idle = 1'b0;
   endtask

   task automatic test_frame_restart();
      configure(4'd2, 4'd1, 4'd1, 4'd1, 1'b0);
      repeat (3) send_pixel(make_pixel(3));
      wait_drained();
      write_reg(CSR_INDEX_W'($urandom_range(CSR_HEIGHT_RATIO_LOG2 + 1, 15)),
                log2_type'($urandom_range(0, 15)));
      csr_we <= 1'b0;
      for (int n = 0; n < 8; n++) send_pixel(make_pixel(n % 4));
   endtask

   task automatic test_ratio_clamp();
      configure(4'd1, 4'd1, 4'd15, 4'd15, 1'b0);
      repeat (4) send_pixel('1);
   endtask

   task automatic test_size_extremes();
      configure(4'd15, 4'd15, 4'd0, 4'd0, 1'b0);
      repeat (60) send_pixel(make_pixel(3));
      configure(4'd12, 4'd12, 4'd12, 4'd12, 1'b0);
      repeat (40) send_pixel(make_pixel(3));
      configure(4'd3, 4'd2, 4'd12, 4'd12, 1'b1);
      repeat (64) send_pixel(make_pixel(2));
      configure(4'd3, 4'd3, 4'd3, 4'd3, 1'b0);
      repeat (64) send_pixel('1);
      configure(4'd0, 4'd0, 4'd15, 4'd15, 1'b0);
      repeat (20) send_pixel(make_pixel(3));
   endtask

   task automatic test_random_frames();
      int sw, sh, wr, hr, total, pattern, pause_at;
      while (random_pixels < RANDOM_PIXELS) begin
         sw = $urandom_range(0, 4);
         sh = $urandom_range(0, 3);
         wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, sw);
         hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, sh);
         configure(log2_type'(sw), log2_type'(sh), log2_type'(wr), log2_type'(hr),
                   $urandom_range(0, 5) == 0);
         total = $urandom_range(1, 3) << (sw + sh);
         // broken frame: stop part way, the next setting restarts it
         if ($urandom_range(0, 3) == 0) total += $urandom_range(0, (1 << (sw + sh)) - 1);
         pattern  = $urandom_range(0, 9);
         pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
         no_idle  = ($urandom_range(0, 4) == 0);
         for (int n = 0; n < total; n++) begin
            if (n == pause_at) wait_drained();
            send_pixel(make_pixel(pattern));
            random_pixels++;
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_unit_image();
      test_frame_restart();
      test_ratio_clamp();
      test_size_extremes();
      test_random_frames();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("streamed %0d pixels under %0d register settings", pixels_sent, settings_used);
      $display("compared %0d block averages, %0d of them closing a frame", blocks_checked,
               frames_seen);
      if (errors == 0) begin
         $display("box_downsample_rgba16 verification clean");
      end else begin
         $display("box_downsample_rgba16 verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: run did not finish, %0d words still awaited", $time,
               expected_blocks.size());
      $display("box_downsample_rgba16 verification failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/bds_pkg.sv
design/box_downsample_rgba16.sv
sim/tb.sv
